### rtl/spc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spc_pkg
// shared constants, types and helper functions of the scan polar-to-cartesian
// converter
// ----------------------------------------------------------------------------
package spc_pkg;

   // sizing
   localparam int RANGE_BITS    = 16;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int SAMPLE_W  = 16;
   localparam int BAM_W     = 16;
   localparam int POINT_W   = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam int TABLE_LEN = 24;
   localparam int STAGES    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
   localparam int FRAC_BITS = 24;
   localparam int GAIN_W    = 24;
   localparam int PROD_W    = SAMPLE_W + GAIN_W;
   localparam int DATA_W    = PROD_W + 2;
   localparam int RES_W     = DATA_W - FRAC_BITS;
   localparam int Z_W       = ANGLE_BITS + 1;
   localparam int ATAN_SHIFT = 32 - ANGLE_BITS;

   localparam logic [GAIN_W-1:0]   GAIN_Q  = GAIN_W'(10188014);
   localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(65535);
   localparam logic [SAMPLE_W-1:0] RANGE_MASK =
      (RANGE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((64'd1 << RANGE_BITS) - 64'd1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_ANGLE = 2'd0,
      CSR_ANGLE_STEP  = 2'd1,
      CSR_RANGE_LOW   = 2'd2,
      CSR_RANGE_HIGH  = 2'd3
   } csr_index_type;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURNS32 [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // one converted sample waiting for the rotator
   typedef struct packed {
      logic [SAMPLE_W-1:0]          sample;
      logic signed [ANGLE_BITS-1:0] z;
      logic                         flip;
   } spc_item_type;

   // arctangent rounded half up to the angle unit
   function automatic logic signed [Z_W-1:0] atan_q(input int idx);
      logic [32:0] t;
      t = {1'b0, ATAN_TURNS32[idx]} + (33'd1 << (ATAN_SHIFT - 1));
      return Z_W'(t >> ATAN_SHIFT);
   endfunction

   // beam angle rescaled to ANGLE_BITS bits of a turn
   function automatic logic [ANGLE_BITS-1:0] angle_scale(input logic [BAM_W-1:0] a);
      logic [BAM_W+ANGLE_BITS-1:0] t;
      t = {a, {ANGLE_BITS{1'b0}}} >> BAM_W;
      return t[ANGLE_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

### rtl/scan_polar_to_cartesian.sv
`default_nettype none
// throughput: one item per cycle while rsp_stall is low, set by the fully pipelined
// cordic (one stage per rotation)
// out-of-window items give no result but still advance the beam angle
// reset: synchronous, clears registers to start 0, step 0, low 0, high 65535, angle 0
// reset also empties the queue and the rotator, in-flight items are dropped
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian
// converts laser scan range samples to cartesian points with a running beam
// angle and a gain-compensated cordic rotator
// ----------------------------------------------------------------------------
module scan_polar_to_cartesian (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [spc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [spc_pkg::CSR_DAT_W-1:0]     csr_wdata,
   // sample items
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [spc_pkg::SAMPLE_W-1:0]      req_range_sample,
   input  wire logic                              req_scan_start,
   // point items
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [spc_pkg::POINT_W-1:0]     rsp_point_x,
   output logic signed [spc_pkg::POINT_W-1:0]     rsp_point_y
);
   import spc_pkg::*;

   logic         accept;
   logic         push;
   logic         take;
   logic         q_empty, q_full;
   spc_item_type front_item, head_item;

   // registers are always writable; the user must change them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // front end stalls only when the queue is full
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // front end: angle tracking, range window, quadrant fold
   spc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .range_sample (req_range_sample),
      .scan_start   (req_scan_start),
      .push         (push),
      .item         (front_item)
   );

   // decouples the front end from rotator back-pressure
   spc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (take),
      .head_item (head_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back end: rotator pipeline and output register
   spc_cordic u_cordic (
      .clock      (clock),
      .reset      (reset),
      .item_avail (!q_empty),
      .item       (head_item),
      .item_take  (take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .point_x    (rsp_point_x),
      .point_y    (rsp_point_y)
   );

endmodule
`default_nettype wire

### rtl/spc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spc_front
// configuration registers, running beam angle, range window and quadrant fold
// ----------------------------------------------------------------------------
module spc_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic [spc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [spc_pkg::CSR_DAT_W-1:0]   csr_wdata,
   input  wire logic                            accept,
   input  wire logic [spc_pkg::SAMPLE_W-1:0]    range_sample,
   input  wire logic                            scan_start,
   output logic                                 push,
   output spc_pkg::spc_item_type                item
);
   import spc_pkg::*;

   logic [BAM_W-1:0]      start_angle_ff, angle_step_ff, beam_ff, beam_in;
   logic [SAMPLE_W-1:0]   range_low_ff, range_high_ff;
   logic [BAM_W-1:0]      angle;
   logic [SAMPLE_W-1:0]   r;
   logic [ANGLE_BITS-1:0] zu;
   logic                  fold;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= '0;
         angle_step_ff  <= '0;
         range_low_ff   <= '0;
         range_high_ff  <= '1;
         beam_ff        <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_START_ANGLE: start_angle_ff <= csr_wdata;
               CSR_ANGLE_STEP:  angle_step_ff  <= csr_wdata;
               CSR_RANGE_LOW:   range_low_ff   <= csr_wdata;
               CSR_RANGE_HIGH:  range_high_ff  <= csr_wdata;
               default: ;
            endcase
         end
         beam_ff <= beam_in;
      end
   end

   always_comb begin
      angle   = scan_start ? start_angle_ff : beam_ff;
      beam_in = accept ? angle + angle_step_ff : beam_ff;
      r       = range_sample & RANGE_MASK;
      push    = accept && (r > range_low_ff) && (r < range_high_ff);
      zu      = angle_scale(angle);
      // second and third quarter turn: rotate by a half turn, negate at the end
      fold    = zu[ANGLE_BITS-1] ^ zu[ANGLE_BITS-2];
      item.sample = r;
      item.z      = signed'({zu[ANGLE_BITS-1] ^ fold, zu[ANGLE_BITS-2:0]});
      item.flip   = fold;
   end

endmodule
`default_nettype wire

### rtl/spc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spc_queue
// short first-in first-out buffer between front end and rotator
// ----------------------------------------------------------------------------
module spc_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  spc_pkg::spc_item_type       push_item,
   input  wire logic                   pop,
   output spc_pkg::spc_item_type       head_item,
   output logic                        empty,
   output logic                        full
);
   import spc_pkg::*;

   spc_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("item written into full queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count lost an item");
`endif

endmodule
`default_nettype wire

### rtl/spc_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spc_cordic
// gain multiply, pipelined rotation-mode cordic, rounding and output register
// ----------------------------------------------------------------------------
module spc_cordic (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         item_avail,
   input  spc_pkg::spc_item_type             item,
   output logic                              item_take,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [spc_pkg::POINT_W-1:0] point_x,
   output logic signed [spc_pkg::POINT_W-1:0] point_y
);
   import spc_pkg::*;

   logic                     advance;
   logic                     vld_ff  [STAGES+1];
   logic signed [DATA_W-1:0] x_ff    [STAGES+1];
   logic signed [DATA_W-1:0] y_ff    [STAGES+1];
   logic signed [Z_W-1:0]    z_ff    [STAGES+1];
   logic                     flip_ff [STAGES+1];
   logic [PROD_W-1:0]        prod;
   logic signed [DATA_W-1:0] xr, yr;
   logic signed [RES_W-1:0]  qx, qy, sx, sy;
   logic                     out_vld_ff;

   assign advance   = !out_vld_ff || !rsp_stall;
   assign item_take = advance && item_avail;
   assign rsp_valid = out_vld_ff;
   assign prod      = PROD_W'(item.sample) * PROD_W'(GAIN_Q);

   // stage 0: x = r * gain inverse, y = 0
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= item_avail;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= signed'({2'b00, prod});
         y_ff[0]    <= '0;
         z_ff[0]    <= Z_W'(item.z);
         flip_ff[0] <= item.flip;
      end
   end

   // one micro-rotation per stage
   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      localparam logic signed [Z_W-1:0] ATAN = atan_q(g);
      logic signed [DATA_W-1:0] dx, dy;
      assign dx = y_ff[g] >>> g;
      assign dy = x_ff[g] >>> g;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[g+1] <= vld_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            if (!z_ff[g][Z_W-1]) begin
               x_ff[g+1] <= x_ff[g] - dx;
               y_ff[g+1] <= y_ff[g] + dy;
               z_ff[g+1] <= z_ff[g] - ATAN;
            end else begin
               x_ff[g+1] <= x_ff[g] + dx;
               y_ff[g+1] <= y_ff[g] - dy;
               z_ff[g+1] <= z_ff[g] + ATAN;
            end
            flip_ff[g+1] <= flip_ff[g];
         end
      end
   end

   // round half up, undo the fold, saturate
   always_comb begin
      xr = x_ff[STAGES] + (DATA_W'(1) <<< (FRAC_BITS - 1));
      yr = y_ff[STAGES] + (DATA_W'(1) <<< (FRAC_BITS - 1));
      qx = RES_W'(xr >>> FRAC_BITS);
      qy = RES_W'(yr >>> FRAC_BITS);
      if (flip_ff[STAGES]) begin
         qx = -qx;
         qy = -qy;
      end
      sx = (qx > OUT_MAX) ? OUT_MAX : ((qx < -OUT_MAX) ? -OUT_MAX : qx);
      sy = (qy > OUT_MAX) ? OUT_MAX : ((qy < -OUT_MAX) ? -OUT_MAX : qy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= vld_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance && vld_ff[STAGES]) begin
         point_x <= POINT_W'(sx);
         point_y <= POINT_W'(sy);
      end
   end

`ifndef SYNTHESIS
   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff[STAGES]) && $stable(vld_ff[0]))
      else $error("rotator moved while output stalled");
   a_take_only_advance: assert property (@(posedge clock) disable iff (reset)
      item_take |-> advance && item_avail)
      else $error("item taken while rotator held");
   a_entry_valid: assert property (@(posedge clock) disable iff (reset)
      item_take |=> vld_ff[0])
      else $error("taken item missing at rotator entry");
`endif

endmodule
`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the scan polar-to-cartesian converter: drives range
// sample items under random back-pressure and idling, predicts every point
// with a bit-true cordic of its own and compares each point item in order
// ----------------------------------------------------------------------------
module tb;
   import spc_pkg::*;

   // predictor sizing, kept independent of the design
   localparam int     ROT_STAGES    = 16;
   localparam int     ROT_FRAC      = 24;
   localparam longint GAIN_INV      = 10188014;   // 1/K in q24
   localparam longint POINT_LIMIT   = 65535;
   localparam int     HOLD_CYCLES   = 300;        // long receiver hold-off
   localparam int     SETTLE_CYCLES = 40;         // longer than an item's path through the pipeline
   localparam logic [BAM_W-1:0] QUARTER_TURN       = 16'h4000;
   localparam logic [BAM_W-1:0] HALF_TURN          = 16'h8000;
   localparam logic [BAM_W-1:0] THREE_QUARTER_TURN = 16'hC000;

   // arctangent of 2^-i, units of 2^-32 turn
   localparam int unsigned ROT_ATAN32 [ROT_STAGES] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861
   };

   typedef struct {
      logic signed [POINT_W-1:0] x;
      logic signed [POINT_W-1:0] y;
   } point_type;

   typedef enum int {STALL_QUIET, STALL_BLOCK, STALL_CHOPPY} stall_mode_type;

   // ------------------------------------------------------------------------
   // point predictor: running beam angle, window test and cordic rotation
   // ------------------------------------------------------------------------
   class point_predictor;
      logic [BAM_W-1:0]    start_angle = '0;
      logic [BAM_W-1:0]    angle_step  = '0;
      logic [SAMPLE_W-1:0] range_low   = '0;
      logic [SAMPLE_W-1:0] range_high  = 16'hFFFF;
      logic [BAM_W-1:0]    beam_angle  = '0;
      point_type           expected_points [$];
      int                  errors = 0;

      function void write_reg(csr_index_type idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_START_ANGLE: start_angle = data;
            CSR_ANGLE_STEP:  angle_step  = data;
            CSR_RANGE_LOW:   range_low   = data;
            CSR_RANGE_HIGH:  range_high  = data;
            default: ;
         endcase
      endfunction

      // q24 coordinate to saturated integer millimetres
      function logic signed [POINT_W-1:0] round_point(longint v, logic flip);
         longint r;
         r = (v + (longint'(1) <<< (ROT_FRAC - 1))) >>> ROT_FRAC;
         if (flip) r = -r;
         if (r > POINT_LIMIT) r = POINT_LIMIT;
         if (r < -POINT_LIMIT) r = -POINT_LIMIT;
         return r[POINT_W-1:0];
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] sample, logic first);
         logic [BAM_W-1:0] zu;
         logic             flip;
         longint           x, y, z, dx, dy, atan_step;
         if (first) beam_angle = start_angle;
         zu = beam_angle;
         beam_angle = beam_angle + angle_step;
         if (!(sample > range_low && sample < range_high)) return;
         // fold the left half-plane onto the right, negate at the end
         flip = 1'b0;
         if (zu >= QUARTER_TURN && zu < THREE_QUARTER_TURN) begin
            zu   = zu - HALF_TURN;
            flip = 1'b1;
         end
         z = longint'($signed(zu));
         x = longint'(sample) * GAIN_INV;
         y = 0;
         for (int i = 0; i < ROT_STAGES; i++) begin
            atan_step = (longint'(ROT_ATAN32[i]) + 32768) >>> 16;
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - atan_step;
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + atan_step;
            end
         end
         expected_points.push_back('{round_point(x, flip), round_point(y, flip)});
      endfunction

      function void check_point(logic signed [POINT_W-1:0] got_x,
                                logic signed [POINT_W-1:0] got_y);
         point_type want;
         if (expected_points.size() == 0) begin
            $error("point item with nothing expected: x %0d y %0d", got_x, got_y);
            errors++;
            return;
         end
         want = expected_points.pop_front();
         if (got_x !== want.x) begin
            $error("point_x: expected %0d, actual %0d", want.x, got_x);
            errors++;
         end
         if (got_y !== want.y) begin
            $error("point_y: expected %0d, actual %0d", want.y, got_y);
            errors++;
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals and block instance
   // ------------------------------------------------------------------------
   logic                               clock = 1'b0;
   logic                               reset;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [CSR_IDX_W-1:0]               csr_index;
   logic [CSR_DAT_W-1:0]               csr_wdata;
   logic                               req_valid;
   logic                               req_stall;
   logic [SAMPLE_W-1:0]                req_range_sample;
   logic                               req_scan_start;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic signed [POINT_W-1:0]          rsp_point_x;
   logic signed [POINT_W-1:0]          rsp_point_y;

   point_predictor points = new;
   bit             hold_req  = 1'b0;   // asks the receiver for a long hold-off
   int             burst_left = 0;     // items still to send back to back
   int             scan_left  = 0;     // items left in the current scan

   scan_polar_to_cartesian u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_range_sample (req_range_sample),
      .req_scan_start   (req_scan_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y)
   );

   // 10-unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #8000000;
      $display("FAILED: results differ");
      $finish;
   end

   // every accepted point item is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         points.check_point(rsp_point_x, rsp_point_y);
   end

   // ------------------------------------------------------------------------
   // receiver: quiet stretches, solid stalls and choppy stalls, plus the
   // long hold-off on request, counted here in cycles
   // ------------------------------------------------------------------------
   initial begin
      stall_mode_type mode;
      int             run_left;
      int             roll;
      mode     = STALL_QUIET;
      run_left = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
            run_left = 0;
         end else begin
            if (run_left == 0) begin
               roll = $urandom_range(99);
               if (roll < 30) begin
                  mode     = STALL_QUIET;
                  run_left = $urandom_range(120, 20);
               end else if (roll < 38) begin
                  mode     = STALL_BLOCK;
                  run_left = $urandom_range(40, 8);
               end else begin
                  mode     = STALL_CHOPPY;
                  run_left = $urandom_range(30, 4);
               end
            end
            case (mode)
               STALL_QUIET:  rsp_stall <= 1'b0;
               STALL_BLOCK:  rsp_stall <= 1'b1;
               default:      rsp_stall <= ($urandom_range(99) < 40);
            endcase
            run_left--;
            @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // sender side tasks
   // ------------------------------------------------------------------------

   // offer one sample item and hold it until the block takes it
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic first);
      req_valid        <= 1'b1;
      req_range_sample <= sample;
      req_scan_start   <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      points.note_sample(sample, first);
   endtask

   // drop valid for a number of cycles, nothing when zero
   task automatic idle_req(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // stop sending until every predicted point has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (points.pending() != 0);
   endtask

   // quiet the block before a register write
   task automatic settle();
      req_valid <= 1'b0;
      while (points.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write, valid left high for the next one
   task automatic csr_put(input csr_index_type idx, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      points.write_reg(idx, data);
   endtask

   task automatic write_config(input logic [15:0] start, input logic [15:0] step,
                               input logic [15:0] low, input logic [15:0] high);
      csr_put(CSR_START_ANGLE, start);
      csr_put(CSR_ANGLE_STEP, step);
      csr_put(CSR_RANGE_LOW, low);
      csr_put(CSR_RANGE_HIGH, high);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // angle register values, extremes well represented
   function automatic logic [15:0] pick_angle();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15) return 16'h8000;
      if (roll < 30) return 16'h7FFF;
      if (roll < 40) return 16'h0000;
      if (roll < 45) return 16'h0001;
      if (roll < 50) return 16'hFFFF;
      return 16'($urandom_range(16'hFFFF, 0));
   endfunction

   // mostly inside the window, some anywhere, some on its edges
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int roll;
      int lo;
      int hi;
      roll = $urandom_range(99);
      lo   = int'(points.range_low);
      hi   = int'(points.range_high);
      if (roll < 70 && hi > lo + 1) return SAMPLE_W'($urandom_range(hi - 1, lo + 1));
      if (roll < 82) return SAMPLE_W'($urandom_range(16'hFFFF, 0));
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return SAMPLE_W'(lo);
         3: return SAMPLE_W'(hi);
         4: return SAMPLE_W'(lo + 1);
         default: return SAMPLE_W'(hi - 1);
      endcase
   endfunction

   // a stream of scans with random content and random lengths
   task automatic run_scans(input int count);
      logic [SAMPLE_W-1:0] sample;
      logic                first;
      int                  roll;
      for (int k = 0; k < count; k++) begin
         if (scan_left == 0) begin
            first = 1'b1;
            roll  = $urandom_range(99);
            if (roll < 10) scan_left = $urandom_range(3, 1);
            else if (roll < 85) scan_left = $urandom_range(200, 20);
            else scan_left = $urandom_range(720, 300);
         end else begin
            // stray restarts in mid scan
            first = ($urandom_range(99) < 2);
         end
         scan_left--;
         sample = pick_sample();
         send_sample(sample, first);
         if (burst_left > 0) burst_left--;
         else if ($urandom_range(99) == 0) burst_left = $urandom_range(80, 30);
         if ($urandom_range(199) == 0) pause_until_drained();
         else if (burst_left == 0) idle_req(pick_gap());
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_START_ANGLE;
      csr_wdata        <= '0;
      req_valid        <= 1'b0;
      req_range_sample <= '0;
      req_scan_start   <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full turn in eighths at near-full range, then range extremes
      write_config(16'd0, 16'd8192, 16'd0, 16'hFFFF);
      send_sample(16'd65534, 1'b1);
      for (int k = 0; k < 7; k++) send_sample(16'd65534, 1'b0);
      send_sample(16'd0, 1'b0);       // not above the low bound
      send_sample(16'd1, 1'b0);
      send_sample(16'hFFFF, 1'b0);    // not below the high bound
      send_sample(16'd32768, 1'b0);
      send_sample(16'd12345, 1'b1);   // restart of the scan
      settle();

      // quarter-turn boundaries and wrap of the beam angle, window edges
      write_config(16'h8000, 16'h4000, 16'd1000, 16'd2000);
      send_sample(16'd1500, 1'b1);
      send_sample(16'd1000, 1'b0);
      send_sample(16'd1001, 1'b0);
      send_sample(16'd1999, 1'b0);
      send_sample(16'd2000, 1'b0);
      send_sample(16'd1500, 1'b0);
      send_sample(16'd1700, 1'b0);
      settle();

      // extreme angles, open window
      write_config(16'h8000, 16'h7FFF, 16'd0, 16'hFFFF);
      run_scans(200);
      settle();

      // empty window: nothing may come back
      write_config(16'h7FFF, 16'h8000, 16'd0, 16'd0);
      run_scans(40);
      settle();

      // receiver holds off for a long stretch while items keep coming
      write_config(16'd0, 16'd1, 16'd100, 16'd65000);
      hold_req = 1'b1;
      burst_left = 150;
      run_scans(150);
      pause_until_drained();
      run_scans(50);
      settle();

      // low bound at the top: still an empty window
      write_config(pick_angle(), 16'hFFFF, 16'hFFFE, 16'hFFFF);
      run_scans(30);
      settle();

      // random settings
      for (int p = 0; p < 7; p++) begin
         logic [15:0] low;
         logic [15:0] high;
         int          roll;
         roll = $urandom_range(99);
         if (roll < 45) low = 16'($urandom_range(3000, 0));
         else if (roll < 70) low = 16'h0000;
         else low = 16'($urandom_range(16'hFFFF, 0));
         roll = $urandom_range(99);
         if (roll < 45) high = 16'($urandom_range(16'hFFFF, 50000));
         else if (roll < 70) high = 16'hFFFF;
         else high = 16'($urandom_range(16'hFFFF, 0));
         write_config(pick_angle(), pick_angle(), low, high);
         run_scans(150);
         settle();
      end

      if (points.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
